[rtl/pdfa_pkg.sv]
// Shared types, codes and helper functions for the programmable DFA engine.
// Used by every module under rtl/; depends on nothing else.
package pdfa_pkg;

    // Sizing
    localparam int NUM_STATES  = 32;
    localparam int NUM_SYMBOLS = 16;
    localparam int STATE_W     = 5;
    localparam int SYM_W       = 4;
    localparam int ACT_W       = 3;
    localparam int STATUS_W    = 3;
    localparam int TBL_DEPTH   = NUM_STATES * NUM_SYMBOLS;
    localparam int TBL_AW      = $clog2(TBL_DEPTH);
    localparam int ENTRY_W     = STATE_W + 1;

    // Stream packing (padded to whole bytes)
    localparam int S_TDATA_BITS = 2 * STATE_W + SYM_W + 1;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W    = ACT_W;
    localparam int M_TDATA_BITS = 1 + STATUS_W + STATE_W;
    localparam int M_TDATA_W    = ((M_TDATA_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;

    typedef logic [STATE_W-1:0]  state_t;
    typedef logic [SYM_W-1:0]    sym_t;
    typedef logic [ACT_W-1:0]    action_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [TBL_AW-1:0]   tbl_addr_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // Actions
    localparam action_t ACT_ADD   = 3'd0;
    localparam action_t ACT_RESET = 3'd1;
    localparam action_t ACT_STEP  = 3'd2;
    localparam action_t ACT_WORD  = 3'd3;
    localparam action_t ACT_EMPTY = 3'd4;

    // Status codes
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_NO_START  = 3'd1;
    localparam status_t ST_EMPTY_ALPH = 3'd2;
    localparam status_t ST_BAD_SYM   = 3'd3;
    localparam status_t ST_NO_TARGET = 3'd4;
    localparam status_t ST_NO_SOURCE = 3'd5;
    localparam status_t ST_DUPLICATE = 3'd6;
    localparam status_t ST_NONDET    = 3'd7;

    // Register indexes
    localparam reg_idx_t REG_START_STATE = 3'd0;
    localparam reg_idx_t REG_START_VALID = 3'd1;
    localparam reg_idx_t REG_STATE_PRES  = 3'd2;
    localparam reg_idx_t REG_ACCEPT_MASK = 3'd3;
    localparam reg_idx_t REG_ALPHA_MASK  = 3'd4;

    typedef struct packed {
        state_t        start_state;
        logic          start_valid;
        logic [31:0]   state_present;
        logic [31:0]   accept_mask;
        logic [15:0]   alphabet_mask;
    } cfg_t;

    typedef struct packed {
        action_t action;
        state_t  from_state;
        sym_t    symbol;
        state_t  to_state;
        logic    word_first;
    } item_t;

    typedef struct packed {
        logic    accepted;
        status_t status;
        state_t  state_now;
    } result_t;

    typedef struct packed {
        logic      rd_en;
        tbl_addr_t rd_addr;
        logic      wr_en;
        tbl_addr_t wr_addr;
        entry_t    wr_data;
    } tbl_req_t;

    function automatic logic slot_ok(input state_t s, input sym_t a);
        return (int'(s) < NUM_STATES) && (int'(a) < NUM_SYMBOLS);
    endfunction

    function automatic tbl_addr_t slot_addr(input state_t s, input sym_t a);
        return tbl_addr_t'(int'(s) * NUM_SYMBOLS + int'(a));
    endfunction

    function automatic logic state_exists(input cfg_t c, input state_t s);
        return (int'(s) < NUM_STATES) && c.state_present[s];
    endfunction

    function automatic logic symbol_known(input cfg_t c, input sym_t a);
        return (int'(a) < NUM_SYMBOLS) && c.alphabet_mask[a];
    endfunction

endpackage

[rtl/pdfa_cfg.sv]
// APB-style configuration registers of the DFA engine.
// Depends on pdfa_pkg.
module pdfa_cfg
    import pdfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_STATE: cfg_reg.start_state   <= pwdata[STATE_W-1:0];
                REG_START_VALID: cfg_reg.start_valid   <= pwdata[0];
                REG_STATE_PRES:  cfg_reg.state_present <= pwdata[31:0];
                REG_ACCEPT_MASK: cfg_reg.accept_mask   <= pwdata[31:0];
                REG_ALPHA_MASK:  cfg_reg.alphabet_mask <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_START_STATE: prdata = CFG_DATA_W'(cfg_reg.start_state);
            REG_START_VALID: prdata = CFG_DATA_W'(cfg_reg.start_valid);
            REG_STATE_PRES:  prdata = CFG_DATA_W'(cfg_reg.state_present);
            REG_ACCEPT_MASK: prdata = CFG_DATA_W'(cfg_reg.accept_mask);
            REG_ALPHA_MASK:  prdata = CFG_DATA_W'(cfg_reg.alphabet_mask);
            default:         prdata = '0;
        endcase
    end

endmodule

[rtl/pdfa_table.sv]
// Transition table memory: one write port, one registered read port,
// and the clearing pass that runs after reset. Depends on pdfa_pkg.
module pdfa_table
    import pdfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  tbl_req_t req,
    output entry_t   rd_data,
    output logic     busy
);

    entry_t    mem [TBL_DEPTH];
    entry_t    rd_data_reg;
    tbl_addr_t clr_cnt_reg;
    logic      clr_busy_reg;

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

    // Clearing pass: one entry per cycle after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == tbl_addr_t'(TBL_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

endmodule

[rtl/pdfa_exec.sv]
// Item sequencer: issues the table read, evaluates the item, writes back
// the table and the walk states, and holds the result register.
// Depends on pdfa_pkg.
module pdfa_exec
    import pdfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  item_t    s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_result,
    output tbl_req_t tbl_req,
    input  entry_t   tbl_rd_data,
    input  logic     tbl_busy
);

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_EXEC = 1'b1;

    logic    phase_reg;
    item_t   item_reg;
    state_t  base_reg;
    state_t  running_state_reg, running_state_next;
    logic    running_set_reg, running_set_next;
    state_t  word_state_reg, word_state_next;
    logic    m_valid_reg;
    result_t res_reg, res_next;

    logic    accept;
    logic    done;
    logic    add_ok;
    state_t  running_now;
    state_t  lk_state;
    logic    ent_valid;
    state_t  ent_next;

    assign running_now = running_set_reg ? running_state_reg : cfg.start_state;
    assign s_ready     = (phase_reg == PH_IDLE) && !tbl_busy;
    assign accept      = s_valid && s_ready;
    assign done        = (phase_reg == PH_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid     = m_valid_reg;
    assign m_result    = res_reg;

    // State to look up for the incoming item
    always_comb begin
        unique case (s_item.action)
            ACT_ADD:  lk_state = s_item.from_state;
            ACT_WORD: lk_state = s_item.word_first ? cfg.start_state : word_state_reg;
            default:  lk_state = running_now;
        endcase
    end

    assign ent_valid = tbl_rd_data[STATE_W] && slot_ok(base_reg, item_reg.symbol);
    assign ent_next  = tbl_rd_data[STATE_W-1:0];

    always_comb begin
        running_state_next = running_state_reg;
        running_set_next   = running_set_reg;
        word_state_next    = word_state_reg;
        add_ok             = 1'b0;
        res_next.accepted  = 1'b0;
        res_next.status    = ST_OK;
        res_next.state_now = running_now;
        unique case (item_reg.action)
            ACT_ADD: begin
                priority if (!symbol_known(cfg, item_reg.symbol)) begin
                    res_next.status = ST_BAD_SYM;
                end else if (!state_exists(cfg, item_reg.to_state)) begin
                    res_next.status = ST_NO_TARGET;
                end else if (!state_exists(cfg, item_reg.from_state)) begin
                    res_next.status = ST_NO_SOURCE;
                end else if (ent_valid) begin
                    res_next.status = (ent_next == item_reg.to_state) ? ST_DUPLICATE
                                                                      : ST_NONDET;
                end else begin
                    add_ok = 1'b1;
                end
            end
            ACT_RESET: begin
                running_set_next   = 1'b0;
                running_state_next = '0;
                res_next.state_now = cfg.start_state;
            end
            ACT_STEP: begin
                priority if (!cfg.start_valid) begin
                    res_next.status = ST_NO_START;
                end else if (cfg.alphabet_mask == '0) begin
                    res_next.status = ST_EMPTY_ALPH;
                end else if (ent_valid) begin
                    running_state_next = ent_next;
                    running_set_next   = 1'b1;
                    res_next.accepted  = cfg.accept_mask[ent_next];
                    res_next.state_now = ent_next;
                end else begin
                    res_next.state_now = running_now;
                end
            end
            ACT_WORD: begin
                priority if (!cfg.start_valid) begin
                    res_next.status = ST_NO_START;
                end else if (cfg.alphabet_mask == '0) begin
                    res_next.status = ST_EMPTY_ALPH;
                end else begin
                    word_state_next   = ent_valid ? ent_next : base_reg;
                    res_next.accepted = cfg.accept_mask[word_state_next];
                end
                res_next.state_now = word_state_next;
            end
            ACT_EMPTY: begin
                priority if (!cfg.start_valid) begin
                    res_next.status = ST_NO_START;
                end else if (cfg.alphabet_mask == '0) begin
                    res_next.status = ST_EMPTY_ALPH;
                end else begin
                    word_state_next   = cfg.start_state;
                    res_next.accepted = cfg.accept_mask[cfg.start_state];
                end
                res_next.state_now = word_state_next;
            end
            default: ;
        endcase
    end

    // Reads are only issued from idle, so a write-back always lands before
    // the next read of the same slot.
    always_comb begin
        tbl_req.rd_en   = accept;
        tbl_req.rd_addr = slot_addr(lk_state, s_item.symbol);
        tbl_req.wr_en   = done && add_ok;
        tbl_req.wr_addr = slot_addr(item_reg.from_state, item_reg.symbol);
        tbl_req.wr_data = {1'b1, item_reg.to_state};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            running_state_reg <= '0;
            running_set_reg   <= 1'b0;
            word_state_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= PH_EXEC;
            end else if (done) begin
                phase_reg <= PH_IDLE;
            end
            if (done) begin
                running_state_reg <= running_state_next;
                running_set_reg   <= running_set_next;
                word_state_reg    <= word_state_next;
                m_valid_reg       <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
            base_reg <= lk_state;
        end
        if (done) begin
            res_reg <= res_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (phase_reg == PH_EXEC))
        else $error("item accepted but sequencer not in exec");

    a_done_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (m_valid_reg && (phase_reg == PH_IDLE)))
        else $error("completed item did not reach result register");

    a_write_only_ok_add: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_req.wr_en |-> ((item_reg.action == ACT_ADD) && (res_next.status == ST_OK)))
        else $error("table written by an item that was not a good load");

    a_no_item_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_busy |-> !s_ready)
        else $error("item taken during table clearing pass");

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_EXEC) && !done) |=>
            ((phase_reg == PH_EXEC) && $stable(item_reg) && $stable(base_reg)))
        else $error("item in flight changed while waiting for result slot");
`endif

endmodule

[rtl/programmable_dfa_engine_core.sv]
// Top level of the programmable DFA engine: stream ports, APB port and
// the table, register and sequencer instances. Depends on pdfa_pkg.
//
// Table-driven DFA with up to 32 states and 16 symbols. Each input item
// either loads a transition, puts the running state back at the start
// state, steps the running state, steps the separate word walk, or ends an
// empty word; each item yields exactly one result item. After reset the
// transition table (512 entries) is cleared one entry per cycle, and
// s_tready stays low until that pass is done; APB writes are taken
// throughout. For each item the accept edge issues the table read; once
// the result register is free, a later edge evaluates the item, writes the
// table and walk states back and loads the result register. A new item is
// taken only when the previous one is through, since the registered table
// read sits in the read-modify-write loop. The result register decouples
// the two sides: a new item is accepted while the previous result still
// waits on m_tready. Configuration registers are to be written only while
// no item is in flight.
module programmable_dfa_engine_core
    import pdfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input item stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // from_state, symbol, to_state, word_first
    input  logic [S_TUSER_W-1:0]  s_tuser,   // action

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // accepted, status, state_now

    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t     cfg;
    item_t    s_item;
    result_t  m_result;
    tbl_req_t tbl_req;
    entry_t   tbl_rd_data;
    logic     tbl_busy;

    // Unpack the input item
    always_comb begin
        s_item.action     = s_tuser[ACT_W-1:0];
        s_item.from_state = s_tdata[STATE_W-1:0];
        s_item.symbol     = s_tdata[STATE_W +: SYM_W];
        s_item.to_state   = s_tdata[STATE_W + SYM_W +: STATE_W];
        s_item.word_first = s_tdata[2 * STATE_W + SYM_W];
    end

    // Pack the result, first field in the low bits
    assign m_tdata = M_TDATA_W'({m_result.state_now, m_result.status, m_result.accepted});

    pdfa_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdfa_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_data (tbl_rd_data),
        .busy    (tbl_busy)
    );

    pdfa_exec u_exec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_item      (s_item),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (m_result),
        .tbl_req     (tbl_req),
        .tbl_rd_data (tbl_rd_data),
        .tbl_busy    (tbl_busy)
    );

endmodule
